// File: rtl/tuple_char_field_compressor_core_macros.svh
// Assertion helpers for the character field compressor.
`ifndef TUPLE_CHAR_FIELD_COMPRESSOR_CORE_MACROS_SVH
`define TUPLE_CHAR_FIELD_COMPRESSOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TCFC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcfc: same-cycle check failed");
`define TCFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcfc: next-cycle check failed");
`else
`define TCFC_ASSERT_IMPLY(label, ante, cons)
`define TCFC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/tcfc_pkg.sv
package tcfc_pkg;

  localparam int LEN_W     = 11;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] NUL_CHAR   = 8'h00;

  typedef enum logic [1:0] {
    CLS_RAW   = 2'd0,
    CLS_NUL   = 2'd1,
    CLS_BLANK = 2'd2,
    CLS_TEXT  = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic       fld_end;
    logic       rec_end;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0]       blank_run;
    logic [7:0]       out_byte;
    logic             emit;
    logic [LEN_W-1:0] record_length;
    logic             record_done;
  } res_t;

endpackage

// File: rtl/tcfc_fifo.sv
// DEPTH must be a power of two so the pointers wrap on their own.
module tcfc_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/tcfc_front.sv
module tcfc_front (
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         data_byte,
  input  logic               char_field,
  input  logic               field_last,
  input  logic               record_last,
  output logic               item_push,
  output tcfc_pkg::item_t    item
);

  assign item_push = push && !full;

  always_comb begin
    item.data    = data_byte;
    item.rec_end = record_last;
    // record end also closes the field
    item.fld_end = field_last || record_last;
    if (!char_field) begin
      item.cls = tcfc_pkg::CLS_RAW;
    end else if (data_byte == tcfc_pkg::NUL_CHAR) begin
      item.cls = tcfc_pkg::CLS_NUL;
    end else if (data_byte == tcfc_pkg::BLANK_CHAR) begin
      item.cls = tcfc_pkg::CLS_BLANK;
    end else begin
      item.cls = tcfc_pkg::CLS_TEXT;
    end
  end

endmodule

// File: rtl/tcfc_back.sv
`include "tuple_char_field_compressor_core_macros.svh"

module tcfc_back #(
  parameter int MAX_RECORD_BYTES = 1024,
  parameter int MAX_FIELD_BYTES  = 255
) (
  input  logic            clk,
  input  logic            rst,
  input  tcfc_pkg::item_t item,
  input  logic            item_valid,
  output logic            item_take,
  input  logic            res_full,
  output logic            res_push,
  output tcfc_pkg::res_t  res
);

  localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 1);
  localparam int SUM_W = ((CNT_W > 9) ? CNT_W : 9) + 1;
  localparam int EXT_W = (CNT_W > tcfc_pkg::LEN_W) ? CNT_W : tcfc_pkg::LEN_W;

  logic [7:0]       pending;
  logic             skip;
  logic [CNT_W-1:0] count;

  logic [7:0]       pending_next;
  logic             skip_next;
  logic [CNT_W-1:0] count_next;
  logic             emit;
  logic [7:0]       run;
  logic [7:0]       ob;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] count_upd;
  logic [EXT_W-1:0] count_ext;

  assign item_take = item_valid && !res_full;
  assign res_push  = item_take;

  always_comb begin
    emit         = 1'b0;
    run          = '0;
    ob           = '0;
    pending_next = pending;
    skip_next    = skip;
    case (item.cls)
      tcfc_pkg::CLS_RAW: begin
        emit         = 1'b1;
        ob           = item.data;
        pending_next = '0;
        skip_next    = 1'b0;
      end
      tcfc_pkg::CLS_NUL: begin
        if (skip) begin
          skip_next = !item.fld_end;
        end else begin
          emit         = 1'b1;
          ob           = tcfc_pkg::NUL_CHAR;
          pending_next = '0;
          skip_next    = !item.fld_end;
        end
      end
      tcfc_pkg::CLS_BLANK: begin
        if (skip) begin
          skip_next = !item.fld_end;
        end else if (item.fld_end) begin
          // drop trailing blanks, terminate the field
          emit         = 1'b1;
          ob           = tcfc_pkg::NUL_CHAR;
          pending_next = '0;
        end else if (pending < 8'(MAX_FIELD_BYTES)) begin
          pending_next = pending + 8'd1;
        end
      end
      tcfc_pkg::CLS_TEXT: begin
        if (skip) begin
          skip_next = !item.fld_end;
        end else begin
          emit         = 1'b1;
          run          = pending;
          ob           = item.data;
          pending_next = '0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // saturate the record length
  always_comb begin
    sum = SUM_W'(count) + SUM_W'(run) + SUM_W'(1);
    if (!emit) begin
      count_upd = count;
    end else if (sum > SUM_W'(MAX_RECORD_BYTES)) begin
      count_upd = CNT_W'(MAX_RECORD_BYTES);
    end else begin
      count_upd = sum[CNT_W-1:0];
    end
    count_ext  = EXT_W'(count_upd);
    count_next = item.rec_end ? '0 : count_upd;
  end

  always_comb begin
    res.blank_run     = run;
    res.out_byte      = ob;
    res.emit          = emit;
    res.record_length = count_ext[tcfc_pkg::LEN_W-1:0];
    res.record_done   = item.rec_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      skip    <= 1'b0;
      count   <= '0;
    end else if (item_take) begin
      pending <= item.rec_end ? 8'd0 : pending_next;
      skip    <= item.rec_end ? 1'b0 : skip_next;
      count   <= count_next;
    end
  end

  `TCFC_ASSERT_IMPLY(a_pending_max, 1'b1, pending <= 8'(MAX_FIELD_BYTES))
  `TCFC_ASSERT_IMPLY(a_count_max, 1'b1, count <= CNT_W'(MAX_RECORD_BYTES))
  `TCFC_ASSERT_NEXT(a_record_clear, item_take && item.rec_end, count == '0 && pending == '0 && !skip)
  `TCFC_ASSERT_IMPLY(a_silent_zero, item_take && !emit, run == '0 && ob == '0)

endmodule

// File: rtl/tuple_char_field_compressor_core.sv
// Character field compressor for a stream of record bytes.
// Input queue: drive data_byte with its flags and raise push; the byte is taken
// on a rising edge with push high and full low. One byte may enter every cycle while full is low.
// Result queue: while empty is low the oldest result sits on blank_run, out_byte,
// emit, record_length and record_done; raise pop to take it. Every input byte
// gives exactly one result, in order; emit low marks a byte that writes nothing.
// A taken byte passes through the classify queue and the back stage into the
// result queue, and its result can be popped once it shows at the head.
// Throughput is one byte per cycle while the result queue is not full; the back
// stage updates its state for each byte it takes.
// The classify queue holds four bytes and the result queue two, so a stalled
// reader backs up the back stage first, then the front, and finally raises full.
// Nothing is lost or repeated while either side stalls.
// Reset (rst, synchronous) empties both queues and clears the pending blank
// count, the skip flag and the record length; no clearing pass is needed.
module tuple_char_field_compressor_core #(
  parameter int MAX_RECORD_BYTES = 1024,
  parameter int MAX_FIELD_BYTES  = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        char_field,
  input  logic        field_last,
  input  logic        record_last,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  blank_run,
  output logic [7:0]  out_byte,
  output logic        emit,
  output logic [10:0] record_length,
  output logic        record_done
);

  localparam int ITEM_W = $bits(tcfc_pkg::item_t);
  localparam int RES_W  = $bits(tcfc_pkg::res_t);

  tcfc_pkg::item_t front_item;
  tcfc_pkg::item_t back_item;
  tcfc_pkg::res_t  back_res;
  tcfc_pkg::res_t  head_res;
  logic            front_push;
  logic            mid_empty;
  logic            back_take;
  logic            res_full;
  logic            res_push;

  tcfc_front u_front (
    .push        (push),
    .full        (full),
    .data_byte   (data_byte),
    .char_field  (char_field),
    .field_last  (field_last),
    .record_last (record_last),
    .item_push   (front_push),
    .item        (front_item)
  );

  tcfc_fifo #(
    .DEPTH (tcfc_pkg::MID_DEPTH),
    .WIDTH (ITEM_W)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_item),
    .full  (full),
    .pop   (back_take),
    .rdata (back_item),
    .empty (mid_empty)
  );

  tcfc_back #(
    .MAX_RECORD_BYTES (MAX_RECORD_BYTES),
    .MAX_FIELD_BYTES  (MAX_FIELD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (back_item),
    .item_valid (!mid_empty),
    .item_take  (back_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res)
  );

  tcfc_fifo #(
    .DEPTH (tcfc_pkg::OUT_DEPTH),
    .WIDTH (RES_W)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (head_res),
    .empty (empty)
  );

  assign blank_run     = head_res.blank_run;
  assign out_byte      = head_res.out_byte;
  assign emit          = head_res.emit;
  assign record_length = head_res.record_length;
  assign record_done   = head_res.record_done;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int MAX_RECORD_BYTES = 1024;
  localparam int MAX_FIELD_BYTES  = 255;
  localparam int RANDOM_ITEMS     = 1750;
  localparam int PHASE_LEN        = 150;
  localparam int HOLD_AT          = 500;
  localparam int HOLD_CYCLES      = 250;
  localparam int PAUSE_AT         = 1200;
  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int DRAIN_CYCLES     = 10;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       chr;
    logic       fld_last;
    logic       rec_last;
  } byte_req_t;

  class compress_tracker;
    logic [7:0]     blank_cnt;
    logic           skipping;
    logic [10:0]    len_cnt;
    tcfc_pkg::res_t due_outputs[$];
    int             errors;

    function new();
      blank_cnt = '0;
      skipping  = 1'b0;
      len_cnt   = '0;
      errors    = 0;
    endfunction

    function void log_byte(byte_req_t r);
      tcfc_pkg::res_t want;
      logic fld_end;
      int   total;
      want    = '0;
      fld_end = r.fld_last | r.rec_last;
      if (!r.chr) begin
        blank_cnt = '0;
        skipping  = 1'b0;
        want.emit = 1'b1;
        want.out_byte = r.data;
      end else if (skipping) begin
        if (fld_end) skipping = 1'b0;
      end else if (r.data == tcfc_pkg::NUL_CHAR) begin
        want.emit     = 1'b1;
        want.out_byte = tcfc_pkg::NUL_CHAR;
        blank_cnt     = '0;
        skipping      = !fld_end;
      end else if (r.data == tcfc_pkg::BLANK_CHAR) begin
        // a blank that closes the field turns into the terminator
        if (fld_end) begin
          want.emit     = 1'b1;
          want.out_byte = tcfc_pkg::NUL_CHAR;
          blank_cnt     = '0;
        end else if (blank_cnt < MAX_FIELD_BYTES) begin
          blank_cnt = blank_cnt + 8'd1;
        end
      end else begin
        want.emit      = 1'b1;
        want.blank_run = blank_cnt;
        want.out_byte  = r.data;
        blank_cnt      = '0;
      end
      if (want.emit) begin
        total = int'(len_cnt) + int'(want.blank_run) + 1;
        if (total > MAX_RECORD_BYTES) total = MAX_RECORD_BYTES;
        len_cnt = 11'(total);
      end
      want.record_length = len_cnt;
      want.record_done   = r.rec_last;
      if (r.rec_last) begin
        len_cnt   = '0;
        blank_cnt = '0;
        skipping  = 1'b0;
      end
      due_outputs.push_back(want);
    endfunction

    function void check_output(tcfc_pkg::res_t got);
      tcfc_pkg::res_t want;
      if (due_outputs.size() == 0) begin
        $error("result popped with no request outstanding");
        errors++;
        return;
      end
      want = due_outputs.pop_front();
      if (got.blank_run !== want.blank_run) begin
        $error("blank_run: expected %0d, got %0d", want.blank_run, got.blank_run);
        errors++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.emit !== want.emit) begin
        $error("emit: expected %0d, got %0d", want.emit, got.emit);
        errors++;
      end
      if (got.record_length !== want.record_length) begin
        $error("record_length: expected %0d, got %0d", want.record_length, got.record_length);
        errors++;
      end
      if (got.record_done !== want.record_done) begin
        $error("record_done: expected %0d, got %0d", want.record_done, got.record_done);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_outputs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = '0;
  logic        char_field = 1'b0;
  logic        field_last = 1'b0;
  logic        record_last = 1'b0;
  logic        pop = 1'b0;
  logic        empty;
  logic [7:0]  blank_run;
  logic [7:0]  out_byte;
  logic        emit;
  logic [10:0] record_length;
  logic        record_done;

  compress_tracker tracker;
  byte_req_t       byte_q[$];
  int              directed_n = 0;
  int              sent_cnt = 0;
  int              hold_left = 0;
  bit              hold_done = 1'b0;
  int              stuck_cycles = 0;
  idle_mode_t      mode = IDLE_NONE;

  tuple_char_field_compressor_core #(
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES),
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .char_field   (char_field),
    .field_last   (field_last),
    .record_last  (record_last),
    .pop          (pop),
    .empty        (empty),
    .blank_run    (blank_run),
    .out_byte     (out_byte),
    .emit         (emit),
    .record_length(record_length),
    .record_done  (record_done)
  );

  always #6 clk = ~clk;

  function automatic idle_mode_t mode_for(int n);
    if (n < directed_n) return IDLE_NONE;
    return idle_mode_t'(((n - directed_n) / PHASE_LEN) % 4);
  endfunction

  function automatic int send_idle_pct();
    case (mode)
      IDLE_SEND: return 55;
      IDLE_BOTH: return 16;
      default:   return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (mode)
      IDLE_RECV: return 55;
      IDLE_BOTH: return 16;
      default:   return 0;
    endcase
  endfunction

  function automatic void add_item(logic [7:0] d, logic c, logic fl, logic rl);
    byte_req_t r;
    r.data     = d;
    r.chr      = c;
    r.fld_last = fl;
    r.rec_last = rl;
    byte_q.push_back(r);
  endfunction

  function automatic logic [7:0] char_byte();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return tcfc_pkg::BLANK_CHAR;
    if (roll < 48) return tcfc_pkg::NUL_CHAR;
    if (roll < 68) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h7e, 8'h21));
  endfunction

  function automatic void add_record();
    int   nf, len, tail;
    logic last_rec, open_end, is_last;
    nf = $urandom_range(6, 1);
    for (int f = 0; f < nf; f++) begin
      last_rec = (f == nf - 1);
      if ($urandom_range(99) < 30) begin
        len = $urandom_range(4, 1);
        for (int k = 0; k < len; k++) begin
          is_last = (k == len - 1);
          add_item(8'($urandom_range(255)), 1'b0, is_last, last_rec && is_last);
        end
      end else begin
        len      = ($urandom_range(99) < 10) ? $urandom_range(24, 11) : $urandom_range(10, 1);
        tail     = ($urandom_range(99) < 40) ? $urandom_range(3, 1) : 0;
        // leave the field open now and then: switch type or end the record mid-field
        open_end = ($urandom_range(99) < 10);
        for (int k = 0; k < len; k++) begin
          is_last = (k == len - 1);
          add_item((k >= len - tail) ? tcfc_pkg::BLANK_CHAR : char_byte(), 1'b1,
                   is_last && !open_end, last_rec && is_last);
        end
      end
    end
  endfunction

  function automatic void add_noise();
    int n;
    n = $urandom_range(5, 1);
    for (int k = 0; k < n; k++)
      add_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
  endfunction

  // long record: saturates the blank count and then the record length
  function automatic void add_long_record();
    for (int k = 0; k < 770; k++)
      add_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)), 1'b0);
    for (int k = 0; k < 260; k++)
      add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b0, 1'b0);
    add_item(8'h5a, 1'b1, 1'b1, 1'b0);
    for (int k = 0; k < 10; k++)
      add_item(8'($urandom_range(255)), 1'b0, 1'b1, k == 9);
  endfunction

  function automatic void build_stimulus();
    bit long_done;
    long_done = 1'b0;
    add_item(8'hff, 1'b0, 1'b1, 1'b0);
    add_item(tcfc_pkg::NUL_CHAR, 1'b0, 1'b1, 1'b0);
    // text with inner blanks, closed by a text byte
    add_item(8'h41, 1'b1, 1'b0, 1'b0);
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b0, 1'b0);
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b0, 1'b0);
    add_item(8'h42, 1'b1, 1'b1, 1'b0);
    // field of blanks only
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b0, 1'b0);
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b0, 1'b0);
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b1, 1'b0);
    // null inside the field, rest skipped
    add_item(8'h78, 1'b1, 1'b0, 1'b0);
    add_item(tcfc_pkg::NUL_CHAR, 1'b1, 1'b0, 1'b0);
    add_item(8'h79, 1'b1, 1'b0, 1'b0);
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b1, 1'b0);
    add_item(tcfc_pkg::NUL_CHAR, 1'b1, 1'b1, 1'b0);
    // switch to a raw field with blanks pending
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b0, 1'b0);
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b0, 1'b0);
    add_item(8'h41, 1'b0, 1'b1, 1'b0);
    add_item(8'hff, 1'b1, 1'b1, 1'b0);
    // record end without field end
    add_item(8'h7a, 1'b1, 1'b0, 1'b0);
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b0, 1'b1);
    add_item(tcfc_pkg::NUL_CHAR, 1'b1, 1'b0, 1'b0);
    add_item(8'h6b, 1'b1, 1'b0, 1'b1);
    add_item(tcfc_pkg::BLANK_CHAR, 1'b1, 1'b1, 1'b1);
    directed_n = byte_q.size();
    while (byte_q.size() < directed_n + RANDOM_ITEMS) begin
      if (!long_done && byte_q.size() > directed_n + 300) begin
        add_long_record();
        long_done = 1'b1;
      end else if ($urandom_range(99) < 5) begin
        add_noise();
      end else begin
        add_record();
      end
    end
  endfunction

  task automatic send_byte(input byte_req_t r);
    // no idling while the reader is held off, so the queues fill up
    while (hold_left == 0 && $urandom_range(99) < send_idle_pct()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    data_byte   <= r.data;
    char_field  <= r.chr;
    field_last  <= r.fld_last;
    record_last <= r.rec_last;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.log_byte(r);
    sent_cnt++;
    mode = mode_for(sent_cnt);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && sent_cnt >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty)
      tracker.check_output({blank_run, out_byte, emit, record_length, record_done});
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    tracker = new();
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < byte_q.size(); i++) begin
      if (i == PAUSE_AT) begin
        // hold the input until every result has drained
        push <= 1'b0;
        do @(posedge clk); while (tracker.outstanding() != 0);
      end
      send_byte(byte_q[i]);
    end
    push <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
